/* hdl/usb_config_descriptor_parser_defines.svh */
// Assertion macros used by the configuration descriptor parser drain module.
`ifndef USB_CONFIG_DESCRIPTOR_PARSER_DEFINES_SVH
`define USB_CONFIG_DESCRIPTOR_PARSER_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define UCDP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define UCDP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ucdp_pkg.sv */
// Types and constants of the configuration descriptor parser.
package ucdp_pkg;

    localparam int MAX_ENDPOINTS = 16;
    localparam int POSITION_BITS = 16;
    localparam int EP_IDX_BITS   = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
    localparam int COUNT_BITS    = 5;

    localparam logic [POSITION_BITS-1:0] POS_LIMIT = {POSITION_BITS{1'b1}};

    // Header byte offsets
    localparam logic [3:0] HDR_OFS_LENGTH   = 4'd0;
    localparam logic [3:0] HDR_OFS_TYPE     = 4'd1;
    localparam logic [3:0] HDR_OFS_TOTAL_LO = 4'd2;
    localparam logic [3:0] HDR_OFS_TOTAL_HI = 4'd3;
    localparam logic [3:0] HDR_OFS_CONFIG   = 4'd5;

    localparam logic [7:0] HDR_LEN       = 8'd9;
    localparam logic [7:0] DESC_MIN_LEN  = 8'd2;
    localparam logic [7:0] IFACE_MIN_LEN = 8'd9;
    localparam logic [7:0] EP_MIN_LEN    = 8'd7;

    localparam logic [7:0] DESC_CONFIG    = 8'd2;
    localparam logic [7:0] DESC_INTERFACE = 8'd4;
    localparam logic [7:0] DESC_ENDPOINT  = 8'd5;

    localparam logic [15:0] MPS_MASK = 16'h07ff;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_NO_IFACE  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] number;
        logic [7:0] cls;
        logic [7:0] subclass;
        logic [7:0] protocol;
        logic [7:0] config_value;
    } t_iface;

    typedef struct packed {
        logic [7:0]  address;
        logic [7:0]  attributes;
        logic [10:0] max_packet;
        logic [7:0]  interval;
    } t_endpoint;

    typedef struct packed {
        t_status               status;
        t_iface                iface;
        logic [COUNT_BITS-1:0] total;
    } t_summary;

endpackage

/* hdl/ucdp_parser.sv */
// Per-byte descriptor walk, chosen interface capture and endpoint capture.
module ucdp_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_take,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_last_byte,
    output logic                             o_ep_we,
    output logic [ucdp_pkg::EP_IDX_BITS-1:0] o_ep_wr_idx,
    output ucdp_pkg::t_endpoint              o_ep_wr,
    output logic                             o_start,
    output ucdp_pkg::t_summary               o_summary
);
    import ucdp_pkg::*;

    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [15:0]              r_total, n_total;
    logic [15:0]              r_start, n_start;
    logic [7:0]               r_dlen, n_dlen;
    logic                     r_sel, n_sel;
    logic                     r_stop, n_stop;
    logic                     r_err, n_err;
    t_iface                   r_iface, n_iface;
    logic [COUNT_BITS-1:0]    r_count, n_count;

    // Scratch holds descriptor bytes one to seven; entry i is byte i+1
    logic [7:0]               r_scr [7];
    logic [7:0]               m_scr [7];
    logic [6:0]               scr_we;

    logic                     ep_we;
    t_endpoint                ep_new;
    logic [15:0]              p16;
    logic [7:0]               off;
    logic [15:0]              mps_raw;
    t_status                  status;

    assign p16     = 16'(r_pos);
    assign off     = 8'(p16 - r_start);
    assign mps_raw = {m_scr[4], m_scr[3]} & MPS_MASK;

    // Hand a finished endpoint to the store
    assign o_ep_we     = ep_we;
    assign o_ep_wr_idx = r_count[EP_IDX_BITS-1:0];
    assign o_ep_wr     = ep_new;

    // Work out the next state for one byte
    always_comb begin
        n_pos   = r_pos;
        n_total = r_total;
        n_start = r_start;
        n_dlen  = r_dlen;
        n_sel   = r_sel;
        n_stop  = r_stop;
        n_err   = r_err;
        n_iface = r_iface;
        n_count = r_count;
        scr_we  = '0;
        ep_we   = 1'b0;
        ep_new  = '0;
        for (int i = 0; i < 7; i++) begin
            m_scr[i] = r_scr[i];
        end
        if (i_take && (r_pos != POS_LIMIT)) begin
            n_pos = r_pos + 1'b1;
            if (p16 < 16'(HDR_LEN)) begin
                // Configuration header
                case (p16[3:0])
                    HDR_OFS_LENGTH: begin
                        if (i_data_byte < HDR_LEN) n_err = 1'b1;
                        n_start = 16'(i_data_byte);
                    end
                    HDR_OFS_TYPE: begin
                        if (i_data_byte != DESC_CONFIG) n_err = 1'b1;
                    end
                    HDR_OFS_TOTAL_LO: n_total = 16'(i_data_byte);
                    HDR_OFS_TOTAL_HI: n_total = {i_data_byte, r_total[7:0]};
                    HDR_OFS_CONFIG:   n_iface.config_value = i_data_byte;
                    default: ;
                endcase
            end else if (!r_err && !r_stop) begin
                if (r_dlen == 8'd0) begin
                    // Wait for the length byte of the next sub-descriptor
                    if (p16 == r_start) begin
                        if (17'(r_start) + 17'd2 > 17'(r_total)) begin
                            n_stop = 1'b1;
                        end else if ((i_data_byte < DESC_MIN_LEN) ||
                                     (17'(r_start) + 17'(i_data_byte) > 17'(r_total))) begin
                            n_err = 1'b1;
                        end else begin
                            n_dlen = i_data_byte;
                        end
                    end
                end else begin
                    // Capture body bytes, merging the current one for the finish
                    for (int i = 0; i < 7; i++) begin
                        if (off == 8'(i + 1)) begin
                            scr_we[i] = 1'b1;
                            m_scr[i]  = i_data_byte;
                        end
                    end
                    if (9'(off) + 9'd1 == 9'(r_dlen)) begin
                        if ((m_scr[0] == DESC_INTERFACE) && (r_dlen >= IFACE_MIN_LEN)) begin
                            if (!r_sel && (m_scr[2] == 8'd0)) begin
                                n_iface.number   = m_scr[1];
                                n_iface.cls      = m_scr[4];
                                n_iface.subclass = m_scr[5];
                                n_iface.protocol = m_scr[6];
                                n_sel            = 1'b1;
                            end else if (r_sel) begin
                                n_stop = 1'b1;
                            end
                        end else if ((m_scr[0] == DESC_ENDPOINT) && (r_dlen >= EP_MIN_LEN) &&
                                     r_sel && (r_count < COUNT_BITS'(MAX_ENDPOINTS))) begin
                            ep_we             = 1'b1;
                            ep_new.address    = m_scr[1];
                            ep_new.attributes = m_scr[2];
                            ep_new.max_packet = mps_raw[10:0];
                            ep_new.interval   = m_scr[5];
                            n_count           = r_count + 1'b1;
                        end
                        n_start = r_start + 16'(r_dlen);
                        n_dlen  = 8'd0;
                    end
                end
            end
        end

        // Status after this byte
        if (n_err || (16'(n_pos) < 16'(HDR_LEN)) || (n_total > 16'(n_pos))) begin
            status = ST_MALFORMED;
        end else if (!n_sel) begin
            status = ST_NO_IFACE;
        end else begin
            status = ST_OK;
        end

        o_start           = i_take && i_last_byte;
        o_summary.status  = status;
        o_summary.iface   = n_iface;
        o_summary.total   = n_count;

        // Clear for the next transfer after the final byte
        if (o_start) begin
            n_pos   = '0;
            n_total = '0;
            n_start = '0;
            n_dlen  = '0;
            n_sel   = 1'b0;
            n_stop  = 1'b0;
            n_err   = 1'b0;
            n_iface = '0;
            n_count = '0;
        end
    end

    // Hold the walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_total <= '0;
            r_start <= '0;
            r_dlen  <= '0;
            r_sel   <= 1'b0;
            r_stop  <= 1'b0;
            r_err   <= 1'b0;
            r_iface <= '0;
            r_count <= '0;
        end else begin
            r_pos   <= n_pos;
            r_total <= n_total;
            r_start <= n_start;
            r_dlen  <= n_dlen;
            r_sel   <= n_sel;
            r_stop  <= n_stop;
            r_err   <= n_err;
            r_iface <= n_iface;
            r_count <= n_count;
        end
    end

    // Write scratch bytes
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 7; i++) begin
            if (scr_we[i]) r_scr[i] <= i_data_byte;
        end
    end

endmodule

/* hdl/ucdp_drain.sv */
// Result sequencer: endpoint store, then stored endpoints and the summary through an output register.
`include "usb_config_descriptor_parser_defines.svh"

module ucdp_drain (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  ucdp_pkg::t_summary               i_summary,
    input  logic                             i_ep_we,
    input  logic [ucdp_pkg::EP_IDX_BITS-1:0] i_ep_wr_idx,
    input  ucdp_pkg::t_endpoint              i_ep_wr,
    output logic                             o_busy,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic [1:0]                       o_status,
    output logic [7:0]                       o_config_value,
    output logic [7:0]                       o_iface_number,
    output logic [7:0]                       o_iface_class,
    output logic [7:0]                       o_iface_subclass,
    output logic [7:0]                       o_iface_protocol,
    output logic [4:0]                       o_endpoint_total,
    output logic [7:0]                       o_ep_address,
    output logic [7:0]                       o_ep_attributes,
    output logic [10:0]                      o_ep_max_packet,
    output logic [7:0]                       o_ep_interval,
    output logic                             o_last
);
    import ucdp_pkg::*;

    logic                   r_busy;
    logic [COUNT_BITS-1:0]  r_idx;
    t_summary               r_sum;
    t_iface                 head_iface;
    logic [COUNT_BITS-1:0]  head_total;
    logic                   is_ok;
    logic                   emit_ep;
    logic                   can_load;

    t_endpoint              r_store [MAX_ENDPOINTS];
    t_endpoint              r_rd_ep;
    logic [COUNT_BITS-1:0]  next_idx;
    logic [EP_IDX_BITS-1:0] rd_addr;

    logic                   r_out_valid;
    t_status                r_out_status;
    t_iface                 r_out_iface;
    logic [COUNT_BITS-1:0]  r_out_total;
    t_endpoint              r_out_ep;
    logic                   r_out_last;

    assign is_ok      = (r_sum.status == ST_OK);
    assign head_iface = is_ok ? r_sum.iface : '0;
    assign head_total = is_ok ? r_sum.total : '0;
    assign emit_ep    = is_ok && (r_idx < r_sum.total);
    assign can_load   = !r_out_valid || !i_out_stall;
    assign o_busy     = r_busy;

    // Read ahead at the index the sequencer holds after this edge
    assign next_idx = i_start ? '0 :
                      ((r_busy && can_load && emit_ep) ? r_idx + 1'b1 : r_idx);
    assign rd_addr  = next_idx[EP_IDX_BITS-1:0];

    // Endpoint store: write from the walk, registered read with write-through
    always_ff @(posedge i_clk) begin
        if (i_ep_we) r_store[i_ep_wr_idx] <= i_ep_wr;
        r_rd_ep <= (i_ep_we && (i_ep_wr_idx == rd_addr)) ? i_ep_wr : r_store[rd_addr];
    end

    // Sequence control: start on the final byte, advance over the endpoints
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy && can_load) begin
                if (emit_ep) r_idx <= r_idx + 1'b1;
                else r_busy <= 1'b0;
            end
            if (can_load) r_out_valid <= r_busy;
        end
    end

    // Summary payload
    always_ff @(posedge i_clk) begin
        if (i_start) r_sum <= i_summary;
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (r_busy && can_load) begin
            r_out_status <= r_sum.status;
            r_out_iface  <= head_iface;
            r_out_total  <= head_total;
            r_out_ep     <= emit_ep ? r_rd_ep : '0;
            r_out_last   <= !emit_ep;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_config_value   = r_out_iface.config_value;
    assign o_iface_number   = r_out_iface.number;
    assign o_iface_class    = r_out_iface.cls;
    assign o_iface_subclass = r_out_iface.subclass;
    assign o_iface_protocol = r_out_iface.protocol;
    assign o_endpoint_total = r_out_total;
    assign o_ep_address     = r_out_ep.address;
    assign o_ep_attributes  = r_out_ep.attributes;
    assign o_ep_max_packet  = r_out_ep.max_packet;
    assign o_ep_interval    = r_out_ep.interval;
    assign o_last           = r_out_last;

    `UCDP_ASSERT_NOW(a_start_when_idle, i_start, !r_busy, "transfer ended while results still drain")
    `UCDP_ASSERT_NEXT(a_busy_after_start, i_start, r_busy, "sequence did not start")
    `UCDP_ASSERT_NOW(a_ep_only_when_ok, r_out_valid && !r_out_last, r_out_status == ST_OK,
        "endpoint item with a failing status")
    `UCDP_ASSERT_NOW(a_ep_index_in_range, r_busy && emit_ep,
        r_idx < COUNT_BITS'(MAX_ENDPOINTS), "endpoint index beyond the store")

endmodule

/* hdl/usb_config_descriptor_parser.sv */
// The final byte sets busy, then the first result item loads into the output register.
// Throughput: one byte per cycle, from the per-byte position compare and field capture.
// After a final byte the input stalls while the results drain through the output
// register, one item per endpoint if the status is OK and then the last item.
// Reset: synchronous, active low; clears the walk state, the sequencer and output valid.
module usb_config_descriptor_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_config_value,
    output logic [7:0]  o_iface_number,
    output logic [7:0]  o_iface_class,
    output logic [7:0]  o_iface_subclass,
    output logic [7:0]  o_iface_protocol,
    output logic [4:0]  o_endpoint_total,
    output logic [7:0]  o_ep_address,
    output logic [7:0]  o_ep_attributes,
    output logic [10:0] o_ep_max_packet,
    output logic [7:0]  o_ep_interval,
    output logic        o_last
);
    import ucdp_pkg::*;

    logic                   take;
    logic                   start;
    logic                   busy;
    t_summary               summary;
    logic                   ep_we;
    logic [EP_IDX_BITS-1:0] ep_wr_idx;
    t_endpoint              ep_wr;

    // Hold bytes off while results drain
    assign o_in_stall = busy;
    assign take       = i_in_valid && !busy;

    ucdp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_ep_we     (ep_we),
        .o_ep_wr_idx (ep_wr_idx),
        .o_ep_wr     (ep_wr),
        .o_start     (start),
        .o_summary   (summary)
    );

    ucdp_drain u_drain (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_summary        (summary),
        .i_ep_we          (ep_we),
        .i_ep_wr_idx      (ep_wr_idx),
        .i_ep_wr          (ep_wr),
        .o_busy           (busy),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_config_value   (o_config_value),
        .o_iface_number   (o_iface_number),
        .o_iface_class    (o_iface_class),
        .o_iface_subclass (o_iface_subclass),
        .o_iface_protocol (o_iface_protocol),
        .o_endpoint_total (o_endpoint_total),
        .o_ep_address     (o_ep_address),
        .o_ep_attributes  (o_ep_attributes),
        .o_ep_max_packet  (o_ep_max_packet),
        .o_ep_interval    (o_ep_interval),
        .o_last           (o_last)
    );

endmodule
